// ===== design/shamh_pkg.sv =====
`timescale 1ns / 1ps

package shamh_pkg;

    // Operation codes carried in the op field of a message word.
    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Padding marker byte appended after the last message byte.
    localparam logic [7:0] PAD_MARKER = 8'h80;

    // Byte index at which the 64-bit length field starts.
    localparam logic [5:0] LEN_START = 6'd56;

    // One word on the message channel.
    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } msg_word_t;

    // One word on the digest channel.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_out_t;

    // Source of the byte shifted into the block register.
    typedef enum logic [1:0] {
        SEL_DATA,
        SEL_MARKER,
        SEL_ZERO,
        SEL_LENGTH
    } byte_sel_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_UPDATE,
        ST_EMIT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      shift_in;
        byte_sel_t sel;
        logic      count_bits;
        logic      start_block;
        logic      round;
        logic      update;
        logic      emit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_last;
        logic fill_len;
        logic round_last;
        logic out_busy;
    } dp_status_t;

    // Initial chaining value.
    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Round constants.
    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                           input logic [31:0] g);
        choose = (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                             input logic [31:0] c);
        majority = (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

// ===== design/sha256_message_hasher.sv =====
`timescale 1ns / 1ps
// SHA-256 hasher over a byte stream.
// Message channel (msg_valid/msg_ready/msg): each word carries op and data_byte.
// An absorb word appends one byte; a finish word pads the message and starts
// the digest. Digest channel (digest_valid/digest_ready/digest) returns eight
// words per finished message, word_index 0 first, last_word set on the eighth.
// An absorb word shifts its byte in on acceptance; every 64th byte then starts
// the 64 rounds, one per cycle, and one chaining update, during which
// msg_ready is low. A finish word shifts in the marker, then one padding byte
// per cycle up to the block end, then the rounds and update of each padded
// block (one or two blocks), then loads the digest into the output buffer.
// The output buffer holds the digest while the block hashes the next message;
// a digest_ready stall only holds back the next finish, which waits before
// loading its digest until the previous eight words have been taken.
// Reset sets the initial chaining value, clears the byte and bit counts and
// discards any digest words not yet taken.
module sha256_message_hasher
    import shamh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_ready,
    input  msg_word_t   msg,
    output logic        digest_valid,
    input  logic        digest_ready,
    output digest_out_t digest
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencing of absorb, padding, rounds and digest load.
    shamh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_ready (msg_ready),
        .msg_op    (msg.op),
        .status    (status),
        .cmd       (cmd)
    );

    // Block register, compression round and output buffer.
    shamh_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (msg.data_byte),
        .out_taken (digest_ready),
        .status    (status),
        .out_word  (digest)
    );

    assign digest_valid = status.out_busy;

endmodule

// ===== design/shamh_ctrl.sv =====
`timescale 1ns / 1ps

module shamh_ctrl
    import shamh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       msg_valid,
    output logic       msg_ready,
    input  logic       msg_op,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        finishing_reg;
    logic        finishing_next;
    logic        len_phase_reg;
    logic        len_phase_next;

    // State and flag registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            finishing_reg <= 1'b0;
            len_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            finishing_reg <= finishing_next;
            len_phase_reg <= len_phase_next;
        end
    end

    // Next state and datapath commands.
    always_comb
    begin
        state_next      = state_reg;
        finishing_next  = finishing_reg;
        len_phase_next  = len_phase_reg;
        msg_ready       = 1'b0;
        cmd             = '0;
        cmd.sel         = SEL_DATA;
        case (state_reg)
            ST_IDLE:
            begin
                msg_ready = 1'b1;
                if (msg_valid)
                begin
                    cmd.shift_in = 1'b1;
                    if (msg_op == OP_ABSORB)
                    begin
                        cmd.sel        = SEL_DATA;
                        cmd.count_bits = 1'b1;
                        if (status.fill_last)
                        begin
                            cmd.start_block = 1'b1;
                            state_next      = ST_ROUND;
                        end
                    end
                    else
                    begin
                        // The length fits in this block only if the marker lands below it.
                        cmd.sel        = SEL_MARKER;
                        finishing_next = 1'b1;
                        len_phase_next = !status.fill_len;
                        if (status.fill_last)
                        begin
                            cmd.start_block = 1'b1;
                            state_next      = ST_ROUND;
                        end
                        else
                        begin
                            state_next = ST_PAD;
                        end
                    end
                end
            end
            ST_PAD:
            begin
                cmd.shift_in = 1'b1;
                cmd.sel      = (len_phase_reg && status.fill_len) ? SEL_LENGTH : SEL_ZERO;
                if (status.fill_last)
                begin
                    cmd.start_block = 1'b1;
                    state_next      = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (status.round_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                if (!finishing_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!len_phase_reg)
                begin
                    len_phase_next = 1'b1;
                    state_next     = ST_PAD;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // Wait until the previous digest has fully drained.
                if (!status.out_busy)
                begin
                    cmd.emit       = 1'b1;
                    finishing_next = 1'b0;
                    len_phase_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/shamh_datapath.sv =====
`timescale 1ns / 1ps

module shamh_datapath
    import shamh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [7:0]  data_byte,
    input  logic        out_taken,
    output dp_status_t  status,
    output digest_out_t out_word
);

    // Block register doubling as the sixteen-word schedule window.
    logic [511:0] block_reg;
    logic [511:0] block_next;
    logic [5:0]   fill_reg;
    logic [5:0]   fill_next;
    logic [63:0]  bits_reg;
    logic [63:0]  bits_next;
    logic [5:0]   round_reg;
    logic [5:0]   round_next;
    logic [31:0]  h_reg [8];
    logic [31:0]  h_next [8];
    logic [31:0]  v_reg [8];
    logic [31:0]  v_next [8];
    logic [31:0]  out_words_reg [8];
    logic [31:0]  out_words_next [8];
    logic [2:0]   out_idx_reg;
    logic [2:0]   out_idx_next;
    logic         out_busy_reg;
    logic         out_busy_next;

    logic [7:0]   in_byte;
    logic [2:0]   len_sel;
    logic [31:0]  w_0;
    logic [31:0]  w_1;
    logic [31:0]  w_9;
    logic [31:0]  w_14;
    logic [31:0]  w_new;
    logic [31:0]  t1;
    logic [31:0]  t2;

    // Schedule taps and one compression round.
    assign w_0   = block_reg[511:480];
    assign w_1   = block_reg[479:448];
    assign w_9   = block_reg[223:192];
    assign w_14  = block_reg[63:32];
    assign w_new = small_sigma1(w_14) + w_9 + small_sigma0(w_1) + w_0;
    assign t1    = v_reg[7] + big_sigma1(v_reg[4]) + choose(v_reg[4], v_reg[5], v_reg[6])
                   + ROUND_K[round_reg] + w_0;
    assign t2    = big_sigma0(v_reg[0]) + majority(v_reg[0], v_reg[1], v_reg[2]);

    // Byte to shift in: message data, marker, zero or big-endian length byte.
    assign len_sel = ~fill_reg[2:0];
    always_comb
    begin
        case (cmd.sel)
            SEL_DATA:   in_byte = data_byte;
            SEL_MARKER: in_byte = PAD_MARKER;
            SEL_LENGTH: in_byte = bits_reg[{len_sel, 3'b000} +: 8];
            default:    in_byte = 8'h00;
        endcase
    end

    // Next values of the datapath registers.
    always_comb
    begin
        block_next     = block_reg;
        fill_next      = fill_reg;
        bits_next      = bits_reg;
        round_next     = round_reg;
        h_next         = h_reg;
        v_next         = v_reg;
        out_words_next = out_words_reg;
        out_idx_next   = out_idx_reg;
        out_busy_next  = out_busy_reg;

        if (cmd.shift_in)
        begin
            block_next = {block_reg[503:0], in_byte};
            fill_next  = fill_reg + 6'd1;
        end
        if (cmd.count_bits)
        begin
            bits_next = bits_reg + 64'd8;
        end
        if (cmd.start_block)
        begin
            round_next = '0;
            v_next     = h_reg;
        end
        if (cmd.round)
        begin
            block_next = {block_reg[479:0], w_new};
            round_next = round_reg + 6'd1;
            v_next[7]  = v_reg[6];
            v_next[6]  = v_reg[5];
            v_next[5]  = v_reg[4];
            v_next[4]  = v_reg[3] + t1;
            v_next[3]  = v_reg[2];
            v_next[2]  = v_reg[1];
            v_next[1]  = v_reg[0];
            v_next[0]  = t1 + t2;
        end
        if (cmd.update)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_next[i] = h_reg[i] + v_reg[i];
            end
        end

        // Output buffer drains one word per handshake.
        if (out_busy_reg && out_taken)
        begin
            for (int i = 0; i < 7; i++)
            begin
                out_words_next[i] = out_words_reg[i + 1];
            end
            out_idx_next = out_idx_reg + 3'd1;
            if (out_idx_reg == 3'd7)
            begin
                out_busy_next = 1'b0;
            end
        end
        if (cmd.emit)
        begin
            out_words_next = h_reg;
            out_idx_next   = '0;
            out_busy_next  = 1'b1;
            h_next         = INIT_HASH;
            fill_next      = '0;
            bits_next      = '0;
        end
    end

    // Control state and chaining value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            bits_reg     <= '0;
            round_reg    <= '0;
            h_reg        <= INIT_HASH;
            out_idx_reg  <= '0;
            out_busy_reg <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            bits_reg     <= bits_next;
            round_reg    <= round_next;
            h_reg        <= h_next;
            out_idx_reg  <= out_idx_next;
            out_busy_reg <= out_busy_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        block_reg     <= block_next;
        v_reg         <= v_next;
        out_words_reg <= out_words_next;
    end

    assign status.fill_last  = (fill_reg == 6'd63);
    assign status.fill_len   = (fill_reg >= LEN_START);
    assign status.round_last = (round_reg == 6'd63);
    assign status.out_busy   = out_busy_reg;

    assign out_word.digest_word = out_words_reg[0];
    assign out_word.word_index  = out_idx_reg;
    assign out_word.last_word   = (out_idx_reg == 3'd7);

endmodule

// ===== design/shamh_checker.sv =====
`timescale 1ns / 1ps

module shamh_checker
    import shamh_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        msg_valid,
    input logic        msg_ready,
    input msg_word_t   msg,
    input logic        digest_valid,
    input logic        digest_ready,
    input digest_out_t digest
);

    // A stalled digest word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && !digest_ready |=> digest_valid && $stable(digest))
    else $error("digest word changed while stalled");

    // Digest words follow one another without gaps, in index order.
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_ready && !digest.last_word
        |=> digest_valid && (digest.word_index == 3'($past(digest.word_index) + 3'd1)))
    else $error("digest word index out of sequence");

    // The last flag marks exactly the eighth word.
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (digest.last_word == (digest.word_index == 3'd7)))
    else $error("last_word does not match word_index");

    // A finish word always leads to padding or compression work.
    assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && msg_ready && (msg.op == OP_FINISH) |=> !msg_ready)
    else $error("message channel ready straight after a finish word");

    // A digest is never followed at once by another.
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_ready && digest.last_word |=> !digest_valid)
    else $error("new digest appeared straight after the last word");

endmodule

bind sha256_message_hasher shamh_checker u_shamh_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .msg_valid    (msg_valid),
    .msg_ready    (msg_ready),
    .msg          (msg),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest       (digest)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench
    import shamh_pkg::*;
();

    // Run control.
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 300;
    localparam int TIMEOUT_CYCLES = 500_000;
    localparam int PHASE_WORDS    = 95;

    // Idle percentages per phase: sender-heavy receiver stalls, then the
    // reverse, then no idling at all.
    localparam int SEND_IDLE_PCT [3] = '{8, 68, 0};
    localparam int RECV_IDLE_PCT [3] = '{68, 8, 0};

    // Message lengths around the padding and block boundaries.
    localparam int NUM_EDGE_LENGTHS = 11;
    localparam int EDGE_LENGTHS [NUM_EDGE_LENGTHS] = '{
        54, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // A message word waiting to be sent, tagged with its idling phase.
    typedef struct {
        msg_word_t   word;
        int unsigned phase;
    } queued_word_t;

    logic        clk;
    logic        rst_n        = 1'b0;
    logic        msg_valid    = 1'b0;
    logic        msg_ready;
    msg_word_t   msg          = '0;
    logic        digest_valid;
    logic        digest_ready = 1'b0;
    digest_out_t digest;

    logic        hold_off      = 1'b0;
    int unsigned current_phase = 0;

    queued_word_t msg_backlog [$];
    digest_out_t  digest_due [$];
    queued_word_t next_item;
    digest_out_t  want_word;

    // Hash state kept alongside the block.
    logic [31:0] hash_state [8];
    logic [7:0]  block_bytes [64];
    int unsigned bytes_held;
    logic [63:0] length_bits;

    int unsigned words_sent    = 0;
    int unsigned messages_done = 0;
    int unsigned words_checked = 0;
    int unsigned longest_msg   = 0;
    int unsigned errors        = 0;

    sha256_message_hasher DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_ready    (msg_ready),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest       (digest)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        logic [63:0] twice;
        twice = {x, x} >> n;
        return twice[31:0];
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++)
            hash_state[i] = SHA_IV[i];
        bytes_held  = 0;
        length_bits = '0;
    endfunction

    // Compress the 64 buffered bytes into the hash state.
    function automatic void run_rounds();
        logic [31:0] sched [16];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] wr, s0, s1, t1, t2;
        for (int j = 0; j < 16; j++)
            sched[j] = {block_bytes[4 * j], block_bytes[4 * j + 1],
                        block_bytes[4 * j + 2], block_bytes[4 * j + 3]};
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        f = hash_state[5];
        g = hash_state[6];
        h = hash_state[7];
        for (int r = 0; r < 64; r++)
        begin
            if (r < 16)
                wr = sched[r];
            else
            begin
                s0 = ror32(sched[(r - 15) & 15], 7) ^ ror32(sched[(r - 15) & 15], 18)
                     ^ (sched[(r - 15) & 15] >> 3);
                s1 = ror32(sched[(r - 2) & 15], 17) ^ ror32(sched[(r - 2) & 15], 19)
                     ^ (sched[(r - 2) & 15] >> 10);
                wr = sched[r & 15] + s0 + sched[(r - 7) & 15] + s1;
                sched[r & 15] = wr;
            end
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + SHA_K[r] + wr;
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g;
            g = f;
            f = e;
            e = d + t1;
            d = c;
            c = b;
            b = a;
            a = t1 + t2;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
        hash_state[5] += f;
        hash_state[6] += g;
        hash_state[7] += h;
    endfunction

    // Apply one accepted message word; a finish queues the eight digest words.
    function automatic void hash_word(input msg_word_t w);
        digest_out_t word_out;
        if (w.op == OP_ABSORB)
        begin
            length_bits += 64'd8;
            block_bytes[bytes_held] = w.data_byte;
            bytes_held++;
            if (bytes_held == 64)
            begin
                run_rounds();
                bytes_held = 0;
            end
        end
        else
        begin
            block_bytes[bytes_held] = PAD_BYTE;
            bytes_held++;
            // No room left for the length field, so pad out a block of its own.
            if (bytes_held > 56)
            begin
                while (bytes_held < 64)
                begin
                    block_bytes[bytes_held] = 8'h00;
                    bytes_held++;
                end
                run_rounds();
                bytes_held = 0;
            end
            while (bytes_held < 56)
            begin
                block_bytes[bytes_held] = 8'h00;
                bytes_held++;
            end
            for (int i = 0; i < 8; i++)
                block_bytes[56 + i] = length_bits[63 - 8 * i -: 8];
            run_rounds();
            for (int i = 0; i < 8; i++)
            begin
                word_out.digest_word = hash_state[i];
                word_out.word_index  = 3'(i);
                word_out.last_word   = (i == 7);
                digest_due.insert(digest_due.size(), word_out);
            end
            messages_done++;
            restart_hash();
        end
    endfunction

    function automatic void push_word(input logic op, input logic [7:0] data,
                                      input int unsigned phase_id);
        queued_word_t item;
        item.word.op        = op;
        item.word.data_byte = data;
        item.phase          = phase_id;
        msg_backlog.insert(msg_backlog.size(), item);
    endfunction

    // Queue a message of random bytes and its finish word; returns the word count.
    function automatic int unsigned queue_message(input int unsigned len,
                                                  input int unsigned phase_id);
        for (int unsigned k = 0; k < len; k++)
            push_word(OP_ABSORB, 8'($urandom_range(255)), phase_id);
        push_word(OP_FINISH, 8'($urandom_range(255)), phase_id);
        if (len > longest_msg)
            longest_msg = len;
        return len + 1;
    endfunction

    // Sender: offers queued words and feeds accepted ones to the hash state.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_valid <= 1'b0;
            msg       <= '0;
        end
        else
        begin
            if (msg_valid && msg_ready)
            begin
                hash_word(msg);
                words_sent++;
            end
            if (!msg_valid || msg_ready)
            begin
                if (msg_backlog.size() != 0
                    && $urandom_range(99) >= SEND_IDLE_PCT[msg_backlog[0].phase])
                begin
                    next_item = msg_backlog.pop_front();
                    msg_valid     <= 1'b1;
                    msg           <= next_item.word;
                    current_phase <= next_item.phase;
                end
                else
                    msg_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls at random and checks each digest word in order.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            digest_ready <= 1'b0;
        else
        begin
            if (digest_valid && digest_ready)
            begin
                if (digest_due.size() == 0)
                begin
                    $error("digest word %h arrived with no message finished",
                           digest.digest_word);
                    errors++;
                end
                else
                begin
                    want_word = digest_due.pop_front();
                    if (digest.digest_word !== want_word.digest_word)
                    begin
                        $error("digest_word: expected %h, got %h",
                               want_word.digest_word, digest.digest_word);
                        errors++;
                    end
                    if (digest.word_index !== want_word.word_index)
                    begin
                        $error("word_index: expected %0d, got %0d",
                               want_word.word_index, digest.word_index);
                        errors++;
                    end
                    if (digest.last_word !== want_word.last_word)
                    begin
                        $error("last_word: expected %0b, got %0b",
                               want_word.last_word, digest.last_word);
                        errors++;
                    end
                    words_checked++;
                end
            end
            digest_ready <= !hold_off
                            && $urandom_range(99) >= RECV_IDLE_PCT[current_phase];
        end
    end

    // Once the last phase begins, the receiver holds off for a long stretch
    // so that a second finished message backs up into the message channel.
    initial
    begin
        while (current_phase != 2)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin : stimulus
        int unsigned phase_id;
        int unsigned phase_words;
        int unsigned msg_len;

        restart_hash();

        // Directed: empty messages back to back, a known short message, the
        // extreme byte values, and finish words carrying bytes to be ignored.
        push_word(OP_FINISH, 8'hff, 0);
        push_word(OP_FINISH, 8'h00, 0);
        push_word(OP_ABSORB, 8'h61, 0);
        push_word(OP_ABSORB, 8'h62, 0);
        push_word(OP_ABSORB, 8'h63, 0);
        push_word(OP_FINISH, 8'h5a, 0);
        push_word(OP_ABSORB, 8'h00, 0);
        push_word(OP_FINISH, 8'h00, 0);
        push_word(OP_ABSORB, 8'hff, 0);
        push_word(OP_FINISH, 8'hff, 0);
        push_word(OP_ABSORB, 8'h55, 0);
        push_word(OP_ABSORB, 8'haa, 0);
        push_word(OP_ABSORB, 8'h01, 0);
        push_word(OP_ABSORB, 8'h80, 0);
        push_word(OP_ABSORB, 8'h7f, 0);
        push_word(OP_ABSORB, 8'hfe, 0);
        push_word(OP_FINISH, 8'h80, 0);

        // Random messages, mostly short, the rest at the padding and block
        // boundaries. The last phase opens with a burst of tiny messages
        // that meets the receiver hold-off.
        for (phase_id = 0; phase_id < 3; phase_id++)
        begin
            phase_words = 0;
            if (phase_id == 2)
                repeat (6) phase_words += queue_message($urandom_range(3), phase_id);
            while (phase_words < PHASE_WORDS)
            begin
                if ($urandom_range(9) < 6)
                    msg_len = $urandom_range(12);
                else
                    msg_len = EDGE_LENGTHS[$urandom_range(NUM_EDGE_LENGTHS - 1)];
                phase_words += queue_message(msg_len, phase_id);
            end
        end

        // Wait for every word to go in and every digest word to come out,
        // then give any stray output time to show up.
        @(negedge clk);
        while (!rst_n || msg_backlog.size() != 0 || msg_valid)
            @(negedge clk);
        while (digest_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Hashed %0d messages from %0d message words, up to %0d bytes long.",
                 messages_done, words_sent, longest_msg);
        $display("Checked %0d digest words under three idling mixes and a %0d-cycle stall.",
                 words_checked, HOLD_CYCLES);
        if (errors == 0)
            $display("[sha256_message_hasher] OK");
        else
            $display("[sha256_message_hasher] ERROR");
        $finish;
    end

    // Watchdog: several times the slowest expected run.
    initial
    begin
        #(TIMEOUT_CYCLES * 10);
        $display("[sha256_message_hasher] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/shamh_pkg.sv
design/shamh_ctrl.sv
design/shamh_datapath.sv
design/sha256_message_hasher.sv
design/shamh_checker.sv
dv/testbench.sv
